// ----- design/gtm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_pkg: shared types and constants of the glyph text measure core
// Holds the table entry layout, the search state encoding, the hand-off
// record between the search and the metrics unit, and register indexes.
// ----------------------------------------------------------------------------
package gtm_pkg;

   localparam int CODE_W  = 16;
   localparam int ADV_W   = 16;
   localparam int GIDX_W  = 8;
   localparam int SUM_W   = 20;
   localparam int NLCNT_W = 16;
   localparam int GCNT_W  = 9;
   localparam int FBIX_W  = 8;
   localparam int DIM_W   = 10;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 10;

   localparam logic [CODE_W-1:0]  NEWLINE_CODE = 16'd10;
   localparam logic [SUM_W-1:0]   SUM_MAX      = 20'hFFFFF;
   localparam logic [NLCNT_W-1:0] NLCNT_MAX    = 16'hFFFF;

   // Item kinds carried in the input tuser bit.
   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_MEASURE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_AW-1:0] CSR_GLYPH_COUNT    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_FALLBACK_INDEX = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_FONT_HEIGHT    = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_LINE_SPACING   = 2'd3;

   typedef struct packed {
      logic [ADV_W-1:0]  adv;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef enum logic [2:0] {
      SRCH_IDLE,
      SRCH_LO,
      SRCH_HI,
      SRCH_MID,
      SRCH_FIN,
      SRCH_FB,
      SRCH_STEP
   } srch_state_type;

   // One finished lookup, handed from the search unit to the metrics unit.
   typedef struct packed {
      logic              valid;
      logic              newline;
      logic              found;
      logic [GIDX_W-1:0] gidx;
      logic [ADV_W-1:0]  adv;
      logic              last;
   } step_type;

   typedef struct packed {
      logic [GIDX_W-1:0] glyph_index;
      logic              glyph_found;
      logic [SUM_W-1:0]  line_width;
      logic [SUM_W-1:0]  max_width;
      logic [SUM_W-1:0]  text_height;
      logic              done_res;
   } result_type;

endpackage

// ----- design/glyph_text_measure_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_measure_core: text metrics from a sorted glyph table
// Loads a code-sorted glyph table and measures text one character per beat:
// line width, widest line and text height, saturating at 20 bits.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  ------------------------------------------------------
//  req_     in         tuser = action (0 load entry, 1 measure character),
//                      tlast = last character of the text,
//                      tdata = entry_index, entry_code, entry_advance,
//                              char_code
//  rsp_     out        tuser = glyph_found, tlast = text closed,
//                      tdata = glyph_index, line_width, max_width,
//                              text_height
//  csr_     in         write enable, register index, write data
//
// A load beat writes the table in the cycle in which it is accepted.
// A character is looked up by bisection, one read per step through the
// table's single read port: first entry, last searched entry, midpoints,
// and on a miss the fallback entry if within the table; a hit ends the
// search early. A newline skips the search. The next beat is accepted in
// the cycle after the hand-off. The result beat passes the fold and result
// stages of the metrics unit and sits in an output register, so the next
// item is accepted while it waits. Reset is synchronous and clears control
// state, the accumulators and the configuration registers, but glyph_count
// resets to one; the table contents are undefined until loaded.
//
module glyph_text_measure_core
   import gtm_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   // Input channel.
   input  logic              req_tvalid,
   output logic              req_tready,
   // tdata: entry_index[7:0], entry_code[23:8], entry_advance[39:24],
   //        char_code[55:40]
   input  logic [55:0]       req_tdata,
   // tuser: action[0]
   input  logic              req_tuser,
   input  logic              req_tlast,
   // Result channel.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tdata: glyph_index[7:0], line_width[27:8], max_width[47:28],
   //        text_height[67:48], zero fill [71:68]
   output logic [71:0]       rsp_tdata,
   // tuser: glyph_found[0]
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   // Configuration write port.
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);

   // Configuration registers. The user must change them only while the core is idle; the block does not enforce this.
   logic [GCNT_W-1:0] glyph_count_ff;
   logic [FBIX_W-1:0] fallback_index_ff;
   logic [DIM_W-1:0]  font_height_ff;
   logic [DIM_W-1:0]  line_spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_count_ff    <= GCNT_W'(1);
         fallback_index_ff <= '0;
         font_height_ff    <= '0;
         line_spacing_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GLYPH_COUNT:    glyph_count_ff    <= csr_wdata[GCNT_W-1:0];
            CSR_FALLBACK_INDEX: fallback_index_ff <= csr_wdata[FBIX_W-1:0];
            CSR_FONT_HEIGHT:    font_height_ff    <= csr_wdata[DIM_W-1:0];
            CSR_LINE_SPACING:   line_spacing_ff   <= csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Table memory connections.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   step_type      step;
   logic          step_ready;
   result_type    rsp;

   gtm_table_ram #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The search unit owns the input channel and the table ports.
   gtm_search #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_search (
      .clock             (clock),
      .reset             (reset),
      .glyph_count       (glyph_count_ff),
      .fallback_index    (fallback_index_ff),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_action        (req_tuser),
      .req_entry_index   (req_tdata[7:0]),
      .req_entry_code    (req_tdata[23:8]),
      .req_entry_advance (req_tdata[39:24]),
      .req_char_code     (req_tdata[55:40]),
      .req_last          (req_tlast),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .step              (step),
      .step_ready        (step_ready)
   );

   // The metrics unit folds each lookup into the running sums and holds
   // the result beat.
   gtm_metrics u_metrics (
      .clock        (clock),
      .reset        (reset),
      .font_height  (font_height_ff),
      .line_spacing (line_spacing_ff),
      .step         (step),
      .step_ready   (step_ready),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp          (rsp)
   );

   assign rsp_tdata = {4'b0000, rsp.text_height, rsp.max_width, rsp.line_width,
                       rsp.glyph_index};
   assign rsp_tuser = rsp.glyph_found;
   assign rsp_tlast = rsp.done_res;

endmodule

// ----- design/gtm_table_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_table_ram: glyph table storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gtm_table_ram
   import gtm_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  entry_type                      wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output entry_type                      rd_data
);

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/gtm_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_search: item intake and bisection lookup
// Writes load beats into the table and runs one table read per step to
// find a character, falling back to the configured entry on a miss.
// ----------------------------------------------------------------------------
module gtm_search
   import gtm_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [GCNT_W-1:0]              glyph_count,
   input  logic [FBIX_W-1:0]              fallback_index,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [GIDX_W-1:0]              req_entry_index,
   input  logic [CODE_W-1:0]              req_entry_code,
   input  logic [ADV_W-1:0]               req_entry_advance,
   input  logic [CODE_W-1:0]              req_char_code,
   input  logic                           req_last,
   output logic                           wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   output entry_type                      wr_data,
   output logic                           rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   input  entry_type                      rd_data,
   output step_type                       step,
   input  logic                           step_ready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_POS = AW'(TABLE_DEPTH - 1);

   srch_state_type    state_ff, state_in;
   logic [CODE_W-1:0] ch_ff, ch_in;
   logic              last_ff, last_in;
   logic              newline_ff, newline_in;
   logic              found_ff, found_in;
   logic [GIDX_W-1:0] pos_ff, pos_in;
   logic [ADV_W-1:0]  adv_ff, adv_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [CODE_W-1:0] code_lo_ff, code_lo_in;
   logic [CODE_W-1:0] code_hi_ff, code_hi_in;

   logic [AW-1:0]     hi_init;
   logic [AW-1:0]     lo_n, hi_n, mid_n;
   logic [CODE_W-1:0] clo_n, chi_n;
   logic              below, hit, cont;
   logic              accept;

   // Highest searched position: a count of zero acts as one, and a count
   // beyond the table acts as the table depth.
   always_comb begin
      if (glyph_count == '0) begin
         hi_init = '0;
      end else if (32'(glyph_count) > 32'(TABLE_DEPTH)) begin
         hi_init = LAST_POS;
      end else begin
         hi_init = AW'(glyph_count - 1'b1);
      end
   end

   // Next bisection bounds from the entry just read.
   always_comb begin
      hit   = (rd_data.code == ch_ff);
      below = (rd_data.code < ch_ff);
      if (state_ff == SRCH_HI) begin
         lo_n  = lo_ff;
         hi_n  = hi_ff;
         clo_n = code_lo_ff;
         chi_n = rd_data.code;
      end else begin
         lo_n  = below ? mid_ff : lo_ff;
         hi_n  = below ? hi_ff : mid_ff;
         clo_n = below ? rd_data.code : code_lo_ff;
         chi_n = below ? code_hi_ff : rd_data.code;
      end
      mid_n = lo_n + ((hi_n - lo_n) >> 1);
      cont  = ((hi_n - lo_n) > AW'(1)) && (clo_n < ch_ff) && (chi_n > ch_ff);
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      last_in    = last_ff;
      newline_in = newline_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      adv_in     = adv_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      code_lo_in = code_lo_ff;
      code_hi_in = code_hi_ff;

      req_ready    = (state_ff == SRCH_IDLE);
      wr_en        = 1'b0;
      wr_addr      = AW'(req_entry_index);
      wr_data.adv  = req_entry_advance;
      wr_data.code = req_entry_code;
      rd_en        = 1'b0;
      rd_addr      = '0;

      step.valid   = (state_ff == SRCH_STEP);
      step.newline = newline_ff;
      step.found   = found_ff;
      step.gidx    = pos_ff;
      step.adv     = adv_ff;
      step.last    = last_ff;

      case (state_ff)
         SRCH_IDLE: begin
            if (accept) begin
               if (req_action == ACT_LOAD) begin
                  wr_en = (32'(req_entry_index) < 32'(TABLE_DEPTH));
               end else begin
                  ch_in    = req_char_code;
                  last_in  = req_last;
                  found_in = 1'b0;
                  pos_in   = '0;
                  adv_in   = '0;
                  lo_in    = '0;
                  hi_in    = hi_init;
                  if (req_char_code == NEWLINE_CODE) begin
                     newline_in = 1'b1;
                     state_in   = SRCH_STEP;
                  end else begin
                     newline_in = 1'b0;
                     rd_en      = 1'b1;
                     rd_addr    = '0;
                     state_in   = SRCH_LO;
                  end
               end
            end
         end
         SRCH_LO: begin
            if (hit) begin
               found_in = 1'b1;
               pos_in   = '0;
               adv_in   = rd_data.adv;
               state_in = SRCH_STEP;
            end else begin
               code_lo_in = rd_data.code;
               rd_en      = 1'b1;
               rd_addr    = hi_ff;
               state_in   = SRCH_HI;
            end
         end
         SRCH_HI: begin
            if (hit) begin
               found_in = 1'b1;
               pos_in   = GIDX_W'(hi_ff);
               adv_in   = rd_data.adv;
               state_in = SRCH_STEP;
            end else begin
               code_hi_in = rd_data.code;
               mid_in     = mid_n;
               rd_en      = 1'b1;
               rd_addr    = mid_n;
               state_in   = cont ? SRCH_MID : SRCH_FIN;
            end
         end
         SRCH_MID: begin
            if (hit) begin
               found_in = 1'b1;
               pos_in   = GIDX_W'(mid_ff);
               adv_in   = rd_data.adv;
               state_in = SRCH_STEP;
            end else begin
               lo_in      = lo_n;
               hi_in      = hi_n;
               code_lo_in = clo_n;
               code_hi_in = chi_n;
               mid_in     = mid_n;
               rd_en      = 1'b1;
               rd_addr    = mid_n;
               state_in   = cont ? SRCH_MID : SRCH_FIN;
            end
         end
         SRCH_FIN: begin
            if (hit) begin
               found_in = 1'b1;
               pos_in   = GIDX_W'(mid_ff);
               adv_in   = rd_data.adv;
               state_in = SRCH_STEP;
            end else begin
               pos_in = fallback_index;
               if (32'(fallback_index) < 32'(TABLE_DEPTH)) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(fallback_index);
                  state_in = SRCH_FB;
               end else begin
                  adv_in   = '0;
                  state_in = SRCH_STEP;
               end
            end
         end
         SRCH_FB: begin
            adv_in   = rd_data.adv;
            state_in = SRCH_STEP;
         end
         SRCH_STEP: begin
            if (step_ready) begin
               state_in = SRCH_IDLE;
            end
         end
         default: begin
            state_in = SRCH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRCH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      last_ff    <= last_in;
      newline_ff <= newline_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      adv_ff     <= adv_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      code_lo_ff <= code_lo_in;
      code_hi_ff <= code_hi_in;
   end

endmodule

// ----- design/gtm_metrics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_metrics: line and text accumulators with the result register
// Folds each lookup into the running widths and newline count, then forms
// the text height and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module gtm_metrics
   import gtm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] font_height,
   input  logic [DIM_W-1:0] line_spacing,
   input  step_type         step,
   output logic             step_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output result_type       rsp
);

   logic [SUM_W-1:0]   cur_ff, cur_in;
   logic [SUM_W-1:0]   widest_ff, widest_in;
   logic [NLCNT_W-1:0] nl_ff, nl_in;
   logic               pend_ff, pend_in;
   logic               valid_ff, valid_in;
   logic [GIDX_W-1:0]  gidx_ff, gidx_in;
   logic               found_ff, found_in;
   logic               last_ff, last_in;
   result_type         rsp_ff, rsp_in;

   logic [SUM_W:0]           width_sum;
   logic [DIM_W:0]           pitch;
   logic [NLCNT_W+DIM_W:0]   pitch_total;
   logic [NLCNT_W+DIM_W+1:0] height_raw;
   logic                     slot_free;

   assign step_ready = !pend_ff;
   assign slot_free  = !valid_ff || rsp_ready;

   always_comb begin
      width_sum   = {1'b0, cur_ff} + (SUM_W + 1)'(step.adv);
      pitch       = {1'b0, font_height} + {1'b0, line_spacing};
      pitch_total = (NLCNT_W + DIM_W + 1)'(nl_ff) * (NLCNT_W + DIM_W + 1)'(pitch);
      height_raw  = (NLCNT_W + DIM_W + 2)'(font_height)
                  + (NLCNT_W + DIM_W + 2)'(pitch_total);
   end

   always_comb begin
      cur_in    = cur_ff;
      widest_in = widest_ff;
      nl_in     = nl_ff;
      pend_in   = pend_ff;
      valid_in  = valid_ff;
      gidx_in   = gidx_ff;
      found_in  = found_ff;
      last_in   = last_ff;
      rsp_in    = rsp_ff;

      // A beat taken by the consumer leaves the output register, whatever
      // else happens in this cycle.
      if (rsp_ready) begin
         valid_in = 1'b0;
      end

      if (step.valid && !pend_ff) begin
         // Stage one: fold the character into the running state.
         pend_in  = 1'b1;
         gidx_in  = step.gidx;
         found_in = step.found;
         last_in  = step.last;
         if (step.newline) begin
            if (cur_ff > widest_ff) begin
               widest_in = cur_ff;
            end
            cur_in = '0;
            if (nl_ff != NLCNT_MAX) begin
               nl_in = nl_ff + 1'b1;
            end
         end else begin
            cur_in = width_sum[SUM_W] ? SUM_MAX : width_sum[SUM_W-1:0];
         end
      end else if (pend_ff && slot_free) begin
         // Stage two: form the result beat and close the text if asked.
         pend_in            = 1'b0;
         valid_in           = 1'b1;
         rsp_in.glyph_index = gidx_ff;
         rsp_in.glyph_found = found_ff;
         rsp_in.line_width  = cur_ff;
         rsp_in.max_width   = (cur_ff > widest_ff) ? cur_ff : widest_ff;
         rsp_in.text_height = (height_raw > (NLCNT_W + DIM_W + 2)'(SUM_MAX)) ?
                              SUM_MAX : height_raw[SUM_W-1:0];
         rsp_in.done_res    = last_ff;
         if (last_ff) begin
            cur_in    = '0;
            widest_in = '0;
            nl_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         widest_ff <= '0;
         nl_ff     <= '0;
         pend_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         cur_ff    <= cur_in;
         widest_ff <= widest_in;
         nl_ff     <= nl_in;
         pend_ff   <= pend_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gidx_ff  <= gidx_in;
      found_ff <= found_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule
